### hw/rtl/binary_temporal_majority_filter_unit_assert.svh
// Assertion macros used by the filter's port-level checker.
`ifndef BINARY_TEMPORAL_MAJORITY_FILTER_UNIT_ASSERT_SVH
`define BINARY_TEMPORAL_MAJORITY_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define BTMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define BTMF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/btmf_pkg.sv
// Types and constants of the binary temporal majority filter.
`timescale 1ns / 1ps

package btmf_pkg;

  localparam int unsigned PixelWidth = 8;
  localparam int unsigned CfgWidth   = 17;

  localparam logic [CfgWidth-1:0]   CfgFramePixelsReset = 17'h10000;
  localparam logic [PixelWidth-1:0] PixelSet            = 8'hFF;
  localparam logic [PixelWidth-1:0] PixelClr            = 8'h00;

  // one result item waiting in the output queue
  typedef struct packed {
    logic [PixelWidth-1:0] pixel;
    logic                  last;
  } out_item_t;

endpackage

### hw/rtl/binary_temporal_majority_filter_unit.sv
// Binary temporal majority filter: per-pixel vote over the last frames of a mask.
//
//   channel    | dir | data                      | side bits
//   -----------+-----+---------------------------+--------------------------
//   s_axis     | in  | tdata[7:0] mask pixel     | -
//   m_axis     | out | tdata[7:0] voted pixel    | tlast frame_end
//   cfg        | in  | wdata[16:0] frame_pixels  | we (write strobe)
//
// One item per cycle sustained while m_axis does not stall; the history RAM has
// one read and one write port and each item does one read and one write-back.
// Each taken item passes the vote stage into the output queue. Stalls on
// m_axis are soaked up by a three-entry output queue; s_axis tready falls only
// when that queue plus the item in the vote stage could not take another. Reset
// needs no clearing pass: a fill count marks which history entries have been
// written, the others read as zero.
`timescale 1ns / 1ps

module binary_temporal_majority_filter_unit #(
  parameter int unsigned HISTORY_FRAMES   = 7,
  parameter int unsigned MAX_FRAME_PIXELS = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream, tdata: [7:0] mask pixel
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [btmf_pkg::PixelWidth-1:0]   s_axis_tdata_i,
  // output stream, tdata: [7:0] voted pixel; tlast: frame_end
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [btmf_pkg::PixelWidth-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  // frame size register
  input  logic                              cfg_we_i,
  input  logic [btmf_pkg::CfgWidth-1:0]     cfg_wdata_i
);

  import btmf_pkg::*;

  localparam int unsigned AddrW   = $clog2(MAX_FRAME_PIXELS);
  localparam int unsigned FillW   = AddrW + 1;
  localparam int unsigned SizeW   = (CfgWidth > AddrW + 1) ? CfgWidth : AddrW + 1;
  localparam int unsigned SlotW   = $clog2(HISTORY_FRAMES);
  localparam int unsigned CntW    = $clog2(HISTORY_FRAMES + 1);
  localparam int unsigned VoteMin = HISTORY_FRAMES / 2 + 1;
  localparam int unsigned QDepth  = 3;
  localparam int unsigned QPtrW   = 2;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [CfgWidth-1:0] frame_pixels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= CfgFramePixelsReset;
    end else if (cfg_we_i) begin
      frame_pixels_q <= cfg_wdata_i;
    end
  end

  // active frame size, clamped to 1 .. MAX_FRAME_PIXELS
  logic [SizeW-1:0] cfg_ext, size;

  always_comb begin
    cfg_ext = SizeW'(frame_pixels_q);
    if (cfg_ext == '0) begin
      size = SizeW'(1);
    end else if (cfg_ext > SizeW'(MAX_FRAME_PIXELS)) begin
      size = SizeW'(MAX_FRAME_PIXELS);
    end else begin
      size = cfg_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Issue stage: position, slot, RAM read
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] pos_q, pos_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic             in_acc;
  logic [SizeW-1:0] pos_ext, addr_ext;
  logic [AddrW-1:0] addr;
  logic             last;
  logic             hit_old;
  logic             pix_set;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign pix_set = (s_axis_tdata_i == PixelSet);

  always_comb begin
    pos_ext  = SizeW'(pos_q);
    // a shrunk size makes the current pixel the last one of its frame
    addr_ext = (pos_ext >= size) ? (size - SizeW'(1)) : pos_ext;
    addr     = addr_ext[AddrW-1:0];
    last     = ((pos_ext + SizeW'(1)) >= size);
    // entries at or above the fill count were never written: they read as zero
    hit_old  = (FillW'(addr) < fill_q);
  end

  always_comb begin
    pos_d  = pos_q;
    slot_d = slot_q;
    fill_d = fill_q;
    if (in_acc) begin
      if (last) begin
        pos_d  = '0;
        slot_d = (slot_q == SlotW'(HISTORY_FRAMES - 1)) ? '0 : slot_q + SlotW'(1);
      end else begin
        pos_d  = addr + AddrW'(1);
      end
      // positions are visited in order from zero, so the written set is 0 .. fill-1
      if (FillW'(addr) == fill_q) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      slot_q <= '0;
      fill_q <= '0;
    end else begin
      pos_q  <= pos_d;
      slot_q <= slot_d;
      fill_q <= fill_d;
    end
  end

  // --------------------------------------------------------------------------
  // Vote stage: modify the history word, write it back, count ones
  // --------------------------------------------------------------------------
  logic                      s1_vld_q;
  logic [AddrW-1:0]          s1_addr_q;
  logic [SlotW-1:0]          s1_slot_q;
  logic                      s1_set_q;
  logic                      s1_last_q;
  logic                      s1_old_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= addr;
      s1_slot_q <= slot_q;
      s1_set_q  <= pix_set;
      s1_last_q <= last;
      s1_old_q  <= hit_old;
    end
  end

  logic [HISTORY_FRAMES-1:0] ram_rdata;
  logic [HISTORY_FRAMES-1:0] base_word, new_word;
  logic [CntW-1:0]           ones;
  logic                      vote;

  // last write-back, forwarded when the next item reads the same entry
  logic                      fw_vld_q;
  logic [AddrW-1:0]          fw_addr_q;
  logic [HISTORY_FRAMES-1:0] fw_word_q;

  btmf_ram #(
    .Width (HISTORY_FRAMES),
    .Depth (MAX_FRAME_PIXELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_addr_q),
    .wdata_i (new_word),
    .re_i    (in_acc),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (fw_vld_q && (fw_addr_q == s1_addr_q)) begin
      base_word = fw_word_q;
    end else if (s1_old_q) begin
      base_word = ram_rdata;
    end else begin
      base_word = '0;
    end
    for (int i = 0; i < HISTORY_FRAMES; i++) begin
      new_word[i] = (SlotW'(i) == s1_slot_q) ? s1_set_q : base_word[i];
    end
    ones = '0;
    for (int i = 0; i < HISTORY_FRAMES; i++) begin
      ones = ones + CntW'(new_word[i]);
    end
    vote = (ones >= CntW'(VoteMin));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_vld_q <= 1'b0;
    end else if (s1_vld_q) begin
      fw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      fw_addr_q <= s1_addr_q;
      fw_word_q <= new_word;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  out_item_t        q_mem_q [QDepth];
  out_item_t        push_item;
  logic [QPtrW-1:0] q_wr_q, q_wr_d, q_rd_q, q_rd_d;
  logic [QPtrW-1:0] q_cnt_q, q_cnt_d;
  logic             push, pop;

  assign push            = s1_vld_q;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign push_item.pixel = vote ? PixelSet : PixelClr;
  assign push_item.last  = s1_last_q;

  always_comb begin
    q_wr_d  = q_wr_q;
    q_rd_d  = q_rd_q;
    q_cnt_d = q_cnt_q;
    if (push) begin
      q_wr_d = (q_wr_q == QPtrW'(QDepth - 1)) ? '0 : q_wr_q + QPtrW'(1);
    end
    if (pop) begin
      q_rd_d = (q_rd_q == QPtrW'(QDepth - 1)) ? '0 : q_rd_q + QPtrW'(1);
    end
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + QPtrW'(1);
    end else if (!push && pop) begin
      q_cnt_d = q_cnt_q - QPtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      q_wr_q  <= q_wr_d;
      q_rd_q  <= q_rd_d;
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_wr_q] <= push_item;
    end
  end

  // room for the item in the vote stage and one more
  assign s_axis_tready_o = ((QPtrW + 1)'(q_cnt_q) + (QPtrW + 1)'(s1_vld_q))
                           < (QPtrW + 1)'(QDepth);

  assign m_axis_tvalid_o = (q_cnt_q != '0);
  assign m_axis_tdata_o  = q_mem_q[q_rd_q].pixel;
  assign m_axis_tlast_o  = q_mem_q[q_rd_q].last;

endmodule

### hw/rtl/btmf_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module btmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/btmf_checker.sv
// Port-level checks of the filter, bound to the top level.
`timescale 1ns / 1ps
`include "binary_temporal_majority_filter_unit_assert.svh"

module btmf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [btmf_pkg::PixelWidth-1:0] s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [btmf_pkg::PixelWidth-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o,
  input logic                            cfg_we_i,
  input logic [btmf_pkg::CfgWidth-1:0]   cfg_wdata_i
);

  import btmf_pkg::*;

  // items taken but not yet delivered
  logic [2:0] open_q, open_d;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    open_d = open_q + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  `BTMF_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
                   "stalled output item changed")

  `BTMF_ASSERT_NOW(a_out_binary, m_axis_tvalid_o,
                   m_axis_tdata_o == PixelSet || m_axis_tdata_o == PixelClr,
                   "output pixel is neither set nor clear")

  `BTMF_ASSERT_NOW(a_no_invented, m_axis_tvalid_o, open_q != 3'd0,
                   "output item without an open input item")

  `BTMF_ASSERT_NOW(a_open_bound, 1'b1, open_q <= 3'd4,
                   "more items in flight than the block can hold")

  // unused here, listed to keep the bind complete
  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata_i, cfg_we_i, cfg_wdata_i};

endmodule

bind binary_temporal_majority_filter_unit btmf_checker u_btmf_checker (.*);

### tb/btmf_stream_checker.sv
// Checker for the binary temporal majority filter: predicts each vote and compares results.
`timescale 1ns / 1ps

module btmf_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [btmf_pkg::PixelWidth-1:0] in_pixel_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [btmf_pkg::PixelWidth-1:0] out_pixel_i,
  input  logic                            out_last_i,
  input  logic                            cfg_we_i,
  input  logic [btmf_pkg::CfgWidth-1:0]   cfg_wdata_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     votes_checked_o,
  output int unsigned                     votes_due_o
);
  import btmf_pkg::*;

  localparam int unsigned Frames    = 7;
  localparam int unsigned MaxPixels = 65536;

  logic [Frames-1:0]   history [MaxPixels];
  int unsigned         position;
  int unsigned         slot;
  logic [CfgWidth-1:0] frame_size_reg;
  out_item_t           votes_due [$];
  int unsigned         mismatch_count;
  int unsigned         checked_count;

  assign mismatches_o    = mismatch_count;
  assign votes_checked_o = checked_count;
  assign votes_due_o     = votes_due.size();

  // write the pixel's bit into the current slot, then vote over the whole history
  function automatic out_item_t vote_on_pixel(logic [PixelWidth-1:0] px);
    int unsigned       span;
    int unsigned       at;
    logic [Frames-1:0] bits;
    out_item_t         res;
    span = (frame_size_reg == '0) ? 1 :
           ((frame_size_reg > MaxPixels) ? MaxPixels : int'(frame_size_reg));
    at = (position >= span) ? span - 1 : position;
    bits = history[at];
    bits[slot] = (px == PixelSet);
    history[at] = bits;
    res.pixel = ($countones(bits) >= Frames / 2 + 1) ? PixelSet : PixelClr;
    res.last  = (position + 1 >= span);
    if (res.last) begin
      position = 0;
      slot = (slot + 1 == Frames) ? 0 : slot + 1;
    end else begin
      position = at + 1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MaxPixels; i++) history[i] = '0;
      position       = 0;
      slot           = 0;
      frame_size_reg = CfgFramePixelsReset;
      votes_due.delete();
      mismatch_count = 0;
      checked_count  = 0;
    end else begin
      if (cfg_we_i) frame_size_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) votes_due.push_back(vote_on_pixel(in_pixel_i));
      if (out_valid_i && out_ready_i) begin
        if (votes_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing due: pixel %0d last %0b",
                   $time, out_pixel_i, out_last_i);
        end else begin
          want = votes_due.pop_front();
          checked_count++;
          if (want.pixel !== out_pixel_i) begin
            mismatch_count++;
            $display("%0t: voted pixel expected %0d, got %0d", $time, want.pixel, out_pixel_i);
          end
          if (want.last !== out_last_i) begin
            mismatch_count++;
            $display("%0t: frame_end expected %0b, got %0b", $time, want.last, out_last_i);
          end
        end
      end
    end
  end

endmodule

### tb/testbench.sv
// Top of the filter testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import btmf_pkg::*;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [PixelWidth-1:0] s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [PixelWidth-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_we_i        = 1'b0;
  logic [CfgWidth-1:0]   cfg_wdata_i     = '0;

  // idling odds, in percent, set per phase by the stimulus
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  // long receiver hold-off: requested by the stimulus, counted by the receiver
  bit          hold_request   = 1'b0;
  bit          hold_taken     = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned pixels_sent = 0;
  int unsigned phases_run  = 0;
  int unsigned mismatches;
  int unsigned votes_checked;
  int unsigned votes_due;

  always #1 clk_i = ~clk_i;

  binary_temporal_majority_filter_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  btmf_stream_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_i     (s_axis_tready_o),
    .in_pixel_i     (s_axis_tdata_i),
    .out_valid_i    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_pixel_i    (m_axis_tdata_o),
    .out_last_i     (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatches_o   (mismatches),
    .votes_checked_o(votes_checked),
    .votes_due_o    (votes_due)
  );

  // Receiver: the only driver of tready. A hold-off request is taken once and
  // counted down here; otherwise tready follows the phase's stall odds.
  always @(posedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = 240;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offer one pixel and wait for it to be taken. tvalid is left high on exit
  // so back-to-back items never see a low/high pair in the same step; it is
  // only dropped on an idle cycle or when the stream pauses.
  task automatic send_pixel(input logic [PixelWidth-1:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixels_sent++;
  endtask

  // Stop offering and wait until every vote due has come back, plus a margin.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (votes_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_frame_size(input logic [CfgWidth-1:0] size);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly clean mask values with a set probability, some arbitrary bytes
  // (which must all count as clear unless exactly 255).
  function automatic logic [PixelWidth-1:0] mask_pixel(input int unsigned set_pct);
    if ($urandom_range(99) < 8) return PixelWidth'($urandom_range(255));
    return ($urandom_range(99) < set_pct) ? PixelSet : PixelClr;
  endfunction

  initial begin : stimulus
    int unsigned         count;
    int unsigned         set_pct;
    logic [CfgWidth-1:0] size;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame size: first frame, only one vote per position so all clear
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFE);
    send_pixel(8'h7F);
    settle();

    // zero frame size behaves as one pixel per frame: every item ends a frame
    set_frame_size('0);
    repeat (4) send_pixel(PixelSet);
    settle();
    set_frame_size(17'd1);
    send_pixel(PixelSet);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(PixelSet);
    settle();

    // sizes above the store clamp to the store depth; top bit and all ones
    set_frame_size(17'h1FFFF);
    send_pixel(PixelSet);
    send_pixel(8'hAA);
    settle();
    set_frame_size(17'h10000);
    send_pixel(8'h55);
    send_pixel(PixelSet);
    settle();

    // shrink mid-frame: position already past the new end closes the frame
    set_frame_size(17'd10);
    repeat (6) send_pixel(PixelSet);
    settle();
    set_frame_size(17'd4);
    repeat (3) send_pixel(PixelClr);
    settle();

    // Random phases. Small frame sizes dominate so each position builds up a
    // full seven-frame history and the vote goes both ways.
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(11))
        0:       size = '0;
        1:       size = 17'h10000 | CfgWidth'($urandom_range(65535));
        2:       size = 17'h10000;
        3:       size = CfgWidth'($urandom_range(9, 40));
        default: size = CfgWidth'($urandom_range(1, 8));
      endcase
      set_frame_size(size);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
        default: begin src_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      // in the first phase the receiver holds off while items keep coming,
      // so the output queue fills and the input has to stall
      if (ph == 0) hold_request = 1'b1;
      set_pct = $urandom_range(20, 80);
      count   = $urandom_range(60, 80);
      for (int i = 0; i < count; i++) begin
        send_pixel(mask_pixel(set_pct));
        // occasional pause mid-phase until everything is back
        if ($urandom_range(99) == 0) settle();
      end
      settle();
      phases_run++;
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (10) @(posedge clk_i);

    $display("Sent %0d pixels over %0d random phases plus directed frame-size cases;",
             pixels_sent, phases_run);
    $display("checked %0d filtered pixels with idle and stall mixes.", votes_checked);
    if (mismatches == 0 && votes_due == 0) begin
      $display("binary_temporal_majority_filter_unit: match");
    end else begin
      $display("binary_temporal_majority_filter_unit: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("binary_temporal_majority_filter_unit: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/btmf_pkg.sv
hw/rtl/btmf_ram.sv
hw/rtl/binary_temporal_majority_filter_unit.sv
hw/rtl/btmf_checker.sv
tb/btmf_stream_checker.sv
tb/testbench.sv
